### hw/rtl/wap_pkg.sv
package wap_pkg;

    // Ring depth. The average is taken by a right shift, so keep it a power of two.
    localparam int WINDOW = 16;
    localparam int IDX_W  = $clog2(WINDOW);

    localparam int SMP_W  = 16;
    localparam int SUM_W  = SMP_W + IDX_W;
    localparam int CUR_W  = 17;
    localparam int PRS_W  = 16;

    // avg*4096/32768 is avg>>3, and the current scale is x10
    localparam int CUR_SHIFT  = 3;
    localparam int CUR_SCALE  = 10;
    localparam int CUR_OFFSET = 4000;
    // 625/1000 reduces exactly to 5/8
    localparam int PRS_MUL    = 5;
    localparam int PRS_SHIFT  = 3;
    localparam int PRD_W      = CUR_W + 3;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    typedef logic [SMP_W-1:0] t_smp;
    typedef logic [CUR_W-1:0] t_cur;
    typedef logic [PRS_W-1:0] t_prs;

    typedef struct packed {
        logic vld;
        t_smp avg;
    } t_q_wr;

    typedef struct packed {
        logic vld;
        t_smp avg;
    } t_q_rd;

    typedef struct packed {
        logic full;
        logic afull;
    } t_q_stat;

endpackage

### hw/rtl/wap_in_if.sv
interface wap_in_if;
    logic             valid;
    logic             ready;
    wap_pkg::t_smp    sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

### hw/rtl/wap_out_if.sv
interface wap_out_if;
    logic             valid;
    logic             ready;
    wap_pkg::t_smp    avg_sample;
    wap_pkg::t_cur    loop_current;
    wap_pkg::t_prs    pressure;

    modport source (output valid, output avg_sample, output loop_current, output pressure,
                    input ready);
    modport sink   (input valid, input avg_sample, input loop_current, input pressure,
                    output ready);
endinterface

### hw/rtl/wap_front.sv
module wap_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    wap_in_if.sink           i_smp,
    input  wap_pkg::t_q_stat i_q_st,
    output wap_pkg::t_q_wr   o_q_wr
);

    wap_pkg::t_smp                    r_ring [wap_pkg::WINDOW];
    wap_pkg::t_smp                    r_old;
    wap_pkg::t_smp                    r_b_smp;
    logic                             r_b_vld;
    logic                             r_b_repl;
    logic                             r_b_push;
    logic [wap_pkg::IDX_W-1:0]        r_idx;
    logic                             r_full;
    logic [wap_pkg::SUM_W-1:0]        r_sum;

    logic                             accept;
    logic                             idx_last;
    logic                             full_after;
    logic [wap_pkg::SUM_W-1:0]        n_sum;

    // room for the item in flight plus the one being taken
    assign i_smp.ready = !(i_q_st.full || (i_q_st.afull && r_b_push));
    assign accept      = i_smp.valid && i_smp.ready;
    assign idx_last    = (r_idx == wap_pkg::IDX_W'(wap_pkg::WINDOW - 1));
    assign full_after  = r_full || idx_last;

    // read-before-write: the oldest entry comes out as the new one goes in
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_old         <= r_ring[r_idx];
            r_ring[r_idx] <= i_smp.sample;
            r_b_smp       <= i_smp.sample;
        end
    end

    assign n_sum = r_sum - (r_b_repl ? wap_pkg::SUM_W'(r_old) : '0)
                 + wap_pkg::SUM_W'(r_b_smp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_full   <= 1'b0;
            r_sum    <= '0;
            r_b_vld  <= 1'b0;
            r_b_repl <= 1'b0;
            r_b_push <= 1'b0;
        end else begin
            r_b_vld  <= accept;
            r_b_push <= accept && full_after;
            if (accept) begin
                r_idx    <= idx_last ? '0 : r_idx + 1'b1;
                r_full   <= full_after;
                r_b_repl <= r_full;
            end
            if (r_b_vld) begin
                r_sum <= n_sum;
            end
        end
    end

    assign o_q_wr.vld = r_b_push;
    assign o_q_wr.avg = wap_pkg::SMP_W'(n_sum >> wap_pkg::IDX_W);

endmodule

### hw/rtl/wap_queue.sv
module wap_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  wap_pkg::t_q_wr   i_wr,
    input  logic             i_pop,
    output wap_pkg::t_q_rd   o_rd,
    output wap_pkg::t_q_stat o_st
);

    wap_pkg::t_smp               r_mem [wap_pkg::Q_DEPTH];
    logic [wap_pkg::QPTR_W-1:0]  r_wp;
    logic [wap_pkg::QPTR_W-1:0]  r_rp;
    logic [wap_pkg::QCNT_W-1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_wr.vld) begin
            r_mem[r_wp] <= i_wr.avg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr.vld) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_wr.vld, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_rd.vld   = (r_cnt != '0);
    assign o_rd.avg   = r_mem[r_rp];
    assign o_st.full  = (r_cnt == wap_pkg::QCNT_W'(wap_pkg::Q_DEPTH));
    assign o_st.afull = (r_cnt >= wap_pkg::QCNT_W'(wap_pkg::Q_DEPTH - 1));

endmodule

### hw/rtl/wap_back.sv
module wap_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  wap_pkg::t_q_rd i_q_rd,
    output logic           o_q_pop,
    wap_out_if.source      o_res
);

    logic                        r_v1;
    wap_pkg::t_smp               r_avg1;
    wap_pkg::t_cur               r_cur1;
    logic                        r_v2;
    wap_pkg::t_smp               r_avg2;
    wap_pkg::t_cur               r_cur2;
    wap_pkg::t_prs               r_prs2;

    logic                        s1_rdy;
    logic                        s2_rdy;
    wap_pkg::t_cur               n_cur;
    logic [wap_pkg::PRD_W-1:0]   n_prd;
    wap_pkg::t_prs               n_prs;

    assign s2_rdy  = !r_v2 || o_res.ready;
    assign s1_rdy  = !r_v1 || s2_rdy;
    assign o_q_pop = i_q_rd.vld && s1_rdy;

    assign n_cur = wap_pkg::CUR_W'(i_q_rd.avg >> wap_pkg::CUR_SHIFT)
                 * wap_pkg::CUR_W'(wap_pkg::CUR_SCALE);

    assign n_prd = wap_pkg::PRD_W'(r_cur1 - wap_pkg::CUR_W'(wap_pkg::CUR_OFFSET))
                 * wap_pkg::PRD_W'(wap_pkg::PRS_MUL);
    assign n_prs = (r_cur1 > wap_pkg::CUR_W'(wap_pkg::CUR_OFFSET))
                 ? wap_pkg::PRS_W'(n_prd >> wap_pkg::PRS_SHIFT) : '0;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_avg1 <= i_q_rd.avg;
            r_cur1 <= n_cur;
        end
        if (r_v1 && s2_rdy) begin
            r_avg2 <= r_avg1;
            r_cur2 <= r_cur1;
            r_prs2 <= n_prs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (s1_rdy) begin
                r_v1 <= o_q_pop;
            end
            if (s2_rdy) begin
                r_v2 <= r_v1;
            end
        end
    end

    assign o_res.valid        = r_v2;
    assign o_res.avg_sample   = r_avg2;
    assign o_res.loop_current = r_cur2;
    assign o_res.pressure     = r_prs2;

endmodule

### hw/rtl/windowed_average_pressure_scaler.sv
// Path: a sample passes the front register, a queue entry, then back stages 1 and 2.
// Throughput: one sample transaction per cycle while the queue has room; the ring port
//   and the running-sum register each handle one sample a cycle.
// Reset: synchronous, active low; clears write index, fill flag, running sum, queue
//   and pipeline valids. Ring contents are not cleared; no clearing pass.
// The first WINDOW-1 samples after reset give no result.
module windowed_average_pressure_scaler (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wap_in_if.sink    i_smp,
    wap_out_if.source o_res
);

    // Front: ring buffer and running sum; emits an average once the ring has filled.
    // Queue: short FIFO of averages, so a stalled output does not block the
    //   front until it fills.
    // Back: two-stage scaling pipeline, current then pressure, with output register.

    wap_pkg::t_q_wr   q_wr;
    wap_pkg::t_q_rd   q_rd;
    wap_pkg::t_q_stat q_st;
    logic             q_pop;

    wap_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (i_smp),
        .i_q_st  (q_st),
        .o_q_wr  (q_wr)
    );

    wap_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_pop   (q_pop),
        .o_rd    (q_rd),
        .o_st    (q_st)
    );

    wap_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_rd  (q_rd),
        .o_q_pop (q_pop),
        .o_res   (o_res)
    );

    // front flow control must never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_wr.vld |-> !q_st.full)
        else $error("queue written while full");

    // the back end pops only what is there
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_rd.vld)
        else $error("queue popped while empty");

    // loop current stays aligned with its average through the back pipeline
    a_cur_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.loop_current ==
            wap_pkg::CUR_W'(o_res.avg_sample >> wap_pkg::CUR_SHIFT)
            * wap_pkg::CUR_W'(wap_pkg::CUR_SCALE)))
        else $error("loop current does not match average");

endmodule

### tb/sv/tb.sv
module tb;

    // One reading as the block presents it on the result channel
    typedef struct {
        wap_pkg::t_smp avg;
        wap_pkg::t_cur cur;
        wap_pkg::t_prs prs;
    } t_reading;

    // Shapes of random bursts
    typedef enum int {
        BURST_WIDE,    // full 16-bit range, every bit toggles
        BURST_KNEE,    // averages around the 4 mA offset, where pressure leaves zero
        BURST_STEADY,  // one value held, so a burst of WINDOW samples or more settles the window on it exactly
        BURST_TOP,     // near full scale
        BURST_FLOOR    // near zero
    } t_burst;

    // Tracks the sample window and holds the readings still owed by the block
    class window_tracker;
        wap_pkg::t_smp ring [wap_pkg::WINDOW];
        int unsigned   slot;
        bit            filled;
        int unsigned   total;
        t_reading      due_readings [$];
        int unsigned   faults;

        function new();
            foreach (ring[i]) ring[i] = '0;
            slot   = 0;
            filled = 1'b0;
            total  = 0;
            faults = 0;
        endfunction

        // Accepted sample transaction: update the window and queue any reading it causes
        function void take_sample(wap_pkg::t_smp s);
            int unsigned avg;
            int unsigned cur;
            int unsigned prs;
            t_reading    r;
            if (filled) total -= ring[slot];
            ring[slot] = s;
            total += s;
            if (slot == wap_pkg::WINDOW - 1) begin
                slot   = 0;
                filled = 1'b1;
            end else begin
                slot++;
            end
            if (!filled) return;
            avg = total / wap_pkg::WINDOW;
            cur = ((avg * 4096) / 32768) * 10;
            prs = (cur > 4000) ? ((cur - 4000) * 625) / 1000 : 0;
            r.avg = wap_pkg::t_smp'(avg);
            r.cur = wap_pkg::t_cur'(cur);
            r.prs = wap_pkg::t_prs'(prs);
            due_readings.push_back(r);
        endfunction

        // Accepted result transaction: compare against the oldest reading owed
        function void compare_reading(wap_pkg::t_smp avg, wap_pkg::t_cur cur,
                                      wap_pkg::t_prs prs);
            t_reading r;
            if (due_readings.size() == 0) begin
                if (faults < 10)
                    $display("result with none due: avg=%0d cur=%0d prs=%0d", avg, cur, prs);
                faults++;
                return;
            end
            r = due_readings.pop_front();
            if (avg !== r.avg || cur !== r.cur || prs !== r.prs) begin
                if (faults < 10)
                    $display("reading mismatch: avg %0d/%0d cur %0d/%0d prs %0d/%0d (exp/act)",
                             r.avg, avg, r.cur, cur, r.prs, prs);
                faults++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    wap_in_if  smp_if ();
    wap_out_if res_if ();

    windowed_average_pressure_scaler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_if),
        .o_res   (res_if)
    );

    window_tracker tracker = new();

    // Idle chances, in percent, for the sample source and the result sink
    int tx_idle_pct;
    int rx_idle_pct;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Hard limit; far beyond the slowest correct run
    initial begin
        #2000000;
        $display("tb: FAIL");
        $finish;
    end

    // Result sink: check what was taken at this edge, then pick ready for the next
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready)
                tracker.compare_reading(res_if.avg_sample, res_if.loop_current,
                                        res_if.pressure);
            res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // One sample transaction. Valid is dropped only when a gap is taken, so a
    // back-to-back transaction never sees valid lowered and raised in one step.
    task automatic send_sample(input wap_pkg::t_smp s);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            smp_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        smp_if.valid  <= 1'b1;
        smp_if.sample <= s;
        do @(posedge i_clk); while (!smp_if.ready);
        tracker.take_sample(s);
    endtask

    // Source holds off until every reading owed has come back
    task automatic drain_readings();
        smp_if.valid <= 1'b0;
        do @(posedge i_clk); while (tracker.due_readings.size() != 0);
    endtask

    // Bursts of random shape; steady and knee bursts dwell on the pressure offset
    task automatic send_bursts(input int n);
        int            sent;
        int            len;
        t_burst        kind;
        wap_pkg::t_smp held;
        wap_pkg::t_smp s;
        sent = 0;
        while (sent < n) begin
            kind = t_burst'($urandom_range(4));
            len  = int'($urandom_range(8, 40));
            held = wap_pkg::t_smp'($urandom_range(3195, 3215));
            for (int k = 0; k < len && sent < n; k++) begin
                case (kind)
                    BURST_WIDE:   s = wap_pkg::t_smp'($urandom);
                    BURST_KNEE:   s = wap_pkg::t_smp'($urandom_range(3150, 3270));
                    BURST_STEADY: s = held;
                    BURST_TOP:    s = wap_pkg::t_smp'($urandom_range(65235, 65535));
                    default:      s = wap_pkg::t_smp'($urandom_range(0, 300));
                endcase
                send_sample(s);
                sent++;
            end
        end
    endtask

    initial begin
        tx_idle_pct = 37;
        rx_idle_pct = 46;
        i_rst_n       <= 1'b0;
        smp_if.valid  <= 1'b0;
        smp_if.sample <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fill with full scale: the filling transaction already gives the top reading
        repeat (wap_pkg::WINDOW) send_sample(16'hFFFF);
        // Replacement of the oldest entries by zeros
        repeat (4) send_sample(16'h0000);
        send_sample(16'd3208);
        send_sample(16'd3207);
        drain_readings();

        send_bursts(460);
        drain_readings();

        tx_idle_pct = 46;
        rx_idle_pct = 37;
        send_bursts(485);
        drain_readings();

        // No idling on either side
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_bursts(485);
        smp_if.valid <= 1'b0;

        while (tracker.due_readings.size() != 0) @(posedge i_clk);
        // Room for any stray late result to show up
        repeat (8) @(posedge i_clk);

        if (tracker.faults == 0 && tracker.due_readings.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/wap_pkg.sv
hw/rtl/wap_in_if.sv
hw/rtl/wap_out_if.sv
hw/rtl/wap_front.sv
hw/rtl/wap_queue.sv
hw/rtl/wap_back.sv
hw/rtl/windowed_average_pressure_scaler.sv
tb/sv/tb.sv
